// ----- src/pdtq_pkg.sv -----
// shared types and constants for the per-duration timeout queue
// no dependencies
package pdtq_pkg;
    localparam int NUM_CHAINS  = 8;
    localparam int CHAIN_DEPTH = 16;
    localparam int CW = $clog2(NUM_CHAINS);
    localparam int PW = $clog2(CHAIN_DEPTH);
    localparam int FW = $clog2(CHAIN_DEPTH + 1);
    localparam int SW = CW + PW;
    localparam int TW = $clog2(NUM_CHAINS * CHAIN_DEPTH + 1);

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_UNLINK   = 3'd1;
    localparam logic [2:0] OP_POP      = 3'd2;
    localparam logic [2:0] OP_EARLIEST = 3'd3;
    localparam logic [2:0] OP_LATEST   = 3'd4;

    // members listed from the top bit down, so opcode lands in the lowest bits
    typedef struct packed {
        logic [47:0] time_value;
        logic        kind_is_timeout;
        logic [31:0] duration_key;
        logic [31:0] timer_id;
        logic [2:0]  opcode;
    } req_t;

    // ok lands in bit 0
    typedef struct packed {
        logic [47:0] time_out;
        logic [31:0] popped_id;
        logic        ok;
    } rsp_t;
endpackage

// ----- src/per_duration_timeout_queue.sv -----
// per-duration timeout queue, top level with sequencer and shared compare unit
// uses pdtq_pkg and pdtq_slot_ram
//
// Usage: one request on the s_ channel (tdata packs opcode, timer_id,
// duration_key, kind_is_timeout, time_value from bit 0 up) gives exactly one
// result on the m_ channel (tdata packs ok, popped_id, time_out).
// The block works on one request at a time; s_axis_tready is low while busy.
// Every request first walks the chain keys. The earliest query and invalid
// opcodes then answer directly, insert writes one slot, and the latest query
// scans the last slot of every non-empty chain; unlink searches the chain
// and shifts down the entries behind the match, plus a front rescan when it
// removes the front of the earliest chain; pop takes the front of the earliest
// chain, shifts down the rest and always rescans the fronts. The search,
// compaction and front rescans all go through the single read port of the
// slot ram. The next request can be taken once the result is loaded.
// Results sit in an output register; the block can take the next request
// while a finished result waits, but stalls its sequencer if a new result
// is ready while the register is still full.
// Reset (aresetn low, synchronous) empties all chains and releases no memory
// contents; no clearing pass is needed.
module per_duration_timeout_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[2:0], timer_id[34:3], duration_key[66:35], kind_is_timeout[67],
    // time_value[115:68], zero pad to 120
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ok[0], popped_id[32:1], time_out[80:33], zero pad to 88
    output logic [87:0]  m_axis_tdata
);
    import pdtq_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FIND    = 4'd1;
    localparam logic [3:0] ST_DISP    = 4'd2;
    localparam logic [3:0] ST_SRCH    = 4'd3;
    localparam logic [3:0] ST_SRCHW   = 4'd4;
    localparam logic [3:0] ST_SHIFT   = 4'd5;
    localparam logic [3:0] ST_SHIFTW  = 4'd6;
    localparam logic [3:0] ST_SCAN    = 4'd7;
    localparam logic [3:0] ST_SCANW   = 4'd8;
    localparam logic [3:0] ST_RDW     = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    logic [3:0]  state_reg;
    req_t        req_reg;
    logic [31:0] chain_key_reg [NUM_CHAINS];
    logic [NUM_CHAINS-1:0] chain_used_reg;
    logic [FW-1:0] chain_fill_reg [NUM_CHAINS];
    logic [TW-1:0] total_reg;
    logic        ech_valid_reg;
    logic [CW-1:0] ech_reg;
    logic [47:0] ech_time_reg;
    logic [CW:0] cnt_reg;       // chain counter, one extra bit for the end
    logic [FW-1:0] pos_reg;
    logic        hit_reg;
    logic [CW-1:0] hit_ch_reg;
    logic        rescan_reg;     // scan for earliest (1) or latest (0)
    logic        best_v_reg;
    logic [CW-1:0] best_c_reg;
    logic [47:0] best_t_reg;
    logic [CW-1:0] cur_c_reg;
    rsp_t        rsp_reg;
    logic        ovalid_reg;
    logic        rsp_ok_reg;
    logic [31:0] rsp_id_reg;
    logic [47:0] rsp_t_reg;

    logic        we;
    logic [SW-1:0] waddr, raddr;
    logic [79:0] wdata, rdata;
    logic [CW-1:0] free_c;

    pdtq_slot_ram u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [CW-1:0] cidx;
    assign cidx = cnt_reg[CW-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, rsp_reg.time_out, rsp_reg.popped_id, rsp_reg.ok};

    // lowest unclaimed chain
    always_comb begin
        free_c = '0;
        for (int i = NUM_CHAINS-1; i >= 0; i--)
            if (!chain_used_reg[i]) free_c = CW'(i);
    end

    // read address comes from the sequencer state
    always_comb begin
        raddr = {cidx, {PW{1'b0}}};
        we    = 1'b0;
        waddr = {hit_ch_reg, pos_reg[PW-1:0]};
        wdata = {req_reg.timer_id, req_reg.time_value};
        unique case (state_reg)
            ST_RDW: we = 1'b1;
            ST_SRCH, ST_SHIFT: raddr = {hit_ch_reg, pos_reg[PW-1:0]};
            ST_SHIFTW: begin
                raddr = {hit_ch_reg, pos_reg[PW-1:0]};
                we    = 1'b1;
                waddr = {hit_ch_reg, PW'(pos_reg - FW'(1))};
                wdata = rdata;
            end
            ST_SCAN: raddr = rescan_reg ? {cidx, {PW{1'b0}}}
                : {cidx, PW'(chain_fill_reg[cidx] - FW'(1))};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            chain_used_reg <= '0;
            total_reg      <= '0;
            ech_valid_reg  <= 1'b0;
            ovalid_reg     <= 1'b0;
            for (int i = 0; i < NUM_CHAINS; i++) chain_fill_reg[i] <= '0;
        end else begin
            if (ovalid_reg && m_axis_tready && state_reg != ST_DONE) ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_axis_tvalid) begin
                    req_reg  <= req_t'(s_axis_tdata[115:0]);
                    cnt_reg  <= '0;
                    hit_reg  <= 1'b0;
                    rsp_ok_reg <= 1'b0;
                    rsp_id_reg <= '0;
                    rsp_t_reg  <= '0;
                    state_reg <= ST_FIND;
                end
                ST_FIND: begin
                    // one chain key compare per cycle
                    if (cnt_reg == (CW+1)'(NUM_CHAINS)) begin
                        state_reg <= ST_DISP;
                    end else begin
                        if (!hit_reg && chain_used_reg[cidx]
                            && chain_key_reg[cidx] == req_reg.duration_key) begin
                            hit_reg <= 1'b1;
                            hit_ch_reg <= cidx;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DISP: begin
                    unique case (req_reg.opcode)
                        OP_INSERT: begin
                            priority if (req_reg.kind_is_timeout && hit_reg
                                && chain_fill_reg[hit_ch_reg] != FW'(CHAIN_DEPTH)) begin
                                pos_reg <= chain_fill_reg[hit_ch_reg];
                                state_reg <= ST_RDW;
                            end else if (req_reg.kind_is_timeout && !hit_reg
                                && !(&chain_used_reg)) begin
                                hit_ch_reg <= free_c;
                                pos_reg <= '0;
                                state_reg <= ST_RDW;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end
                        OP_UNLINK: if (hit_reg && total_reg != '0) begin
                            pos_reg <= '0;
                            state_reg <= ST_SRCH;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                        OP_POP: if (ech_valid_reg && !(req_reg.time_value < ech_time_reg)) begin
                            hit_ch_reg <= ech_reg;
                            pos_reg <= '0;
                            rsp_ok_reg <= 1'b1;
                            state_reg <= ST_SRCH;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                        OP_EARLIEST: begin
                            if (ech_valid_reg) begin
                                rsp_ok_reg <= 1'b1;
                                rsp_t_reg  <= ech_time_reg;
                            end
                            state_reg <= ST_DONE;
                        end
                        OP_LATEST: if (total_reg != '0) begin
                            rsp_ok_reg <= 1'b1;
                            rescan_reg <= 1'b0;
                            best_v_reg <= 1'b0;
                            cnt_reg <= '0;
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_RDW: begin
                    // insert write (address from pos_reg)
                    if (!chain_used_reg[hit_ch_reg]) begin
                        chain_used_reg[hit_ch_reg] <= 1'b1;
                        chain_key_reg[hit_ch_reg] <= req_reg.duration_key;
                    end
                    chain_fill_reg[hit_ch_reg] <= pos_reg + FW'(1);
                    total_reg <= total_reg + TW'(1);
                    rsp_ok_reg <= 1'b1;
                    if (pos_reg == '0 && (!ech_valid_reg
                        || req_reg.time_value < ech_time_reg)) begin
                        ech_valid_reg <= 1'b1;
                        ech_reg <= hit_ch_reg;
                        ech_time_reg <= req_reg.time_value;
                    end
                    state_reg <= ST_DONE;
                end
                ST_SRCH: begin
                    if (pos_reg == chain_fill_reg[hit_ch_reg]) state_reg <= ST_DONE;
                    else state_reg <= ST_SRCHW;
                end
                ST_SRCHW: begin
                    // pop takes the front; unlink compares ids
                    if (req_reg.opcode == OP_POP || rdata[79:48] == req_reg.timer_id) begin
                        if (req_reg.opcode == OP_POP) rsp_id_reg <= rdata[79:48];
                        rsp_ok_reg <= 1'b1;
                        hit_reg <= (pos_reg == '0);  // front removed
                        pos_reg <= pos_reg + FW'(1);
                        state_reg <= ST_SHIFT;
                    end else begin
                        pos_reg <= pos_reg + FW'(1);
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SHIFT: begin
                    if (pos_reg == chain_fill_reg[hit_ch_reg]) begin
                        chain_fill_reg[hit_ch_reg] <= chain_fill_reg[hit_ch_reg] - FW'(1);
                        total_reg <= total_reg - TW'(1);
                        if ((hit_reg && ech_reg == hit_ch_reg && ech_valid_reg)
                            || req_reg.opcode == OP_POP) begin
                            rescan_reg <= 1'b1;
                            best_v_reg <= 1'b0;
                            cnt_reg <= '0;
                            state_reg <= ST_SCAN;
                        end else begin
                            if (total_reg == TW'(1)) ech_valid_reg <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        state_reg <= ST_SHIFTW;
                    end
                end
                ST_SHIFTW: begin
                    pos_reg <= pos_reg + FW'(1);
                    state_reg <= ST_SHIFT;
                end
                ST_SCAN: begin
                    if (cnt_reg == (CW+1)'(NUM_CHAINS)) begin
                        if (rescan_reg) begin
                            ech_valid_reg <= best_v_reg;
                            ech_reg <= best_c_reg;
                            ech_time_reg <= best_t_reg;
                        end else begin
                            rsp_t_reg <= best_v_reg ? best_t_reg : 48'd0;
                        end
                        state_reg <= ST_DONE;
                    end else begin
                        cur_c_reg <= cidx;
                        state_reg <= ST_SCANW;
                    end
                end
                ST_SCANW: begin
                    // shared compare: earliest uses strict less, latest strict greater
                    if (chain_fill_reg[cur_c_reg] != '0 && (!best_v_reg
                        || (rescan_reg ? rdata[47:0] < best_t_reg
                                       : rdata[47:0] > best_t_reg))) begin
                        best_v_reg <= 1'b1;
                        best_c_reg <= cur_c_reg;
                        best_t_reg <= rdata[47:0];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= ST_SCAN;
                end
                ST_DONE: if (!ovalid_reg || m_axis_tready) begin
                    rsp_reg <= '{ok: rsp_ok_reg, popped_id: rsp_id_reg, time_out: rsp_t_reg};
                    ovalid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted a request while busy");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg == '0) |-> !ech_valid_reg || state_reg != ST_IDLE)
        else $error("earliest chain valid on empty queue");
`endif
endmodule

// ----- src/pdtq_slot_ram.sv -----
// slot store: timer id and expiry tick for every chain position
// uses pdtq_pkg; one write port, one registered read port
module pdtq_slot_ram (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [pdtq_pkg::SW-1:0] waddr,
    input  logic [79:0]          wdata,
    input  logic [pdtq_pkg::SW-1:0] raddr,
    output logic [79:0]          rdata
);
    import pdtq_pkg::*;
    logic [79:0] mem [NUM_CHAINS*CHAIN_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
